### rtl/sps_pkg.sv
`default_nettype none
package sps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = 4;
  localparam int PRI_W     = 6;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 5;
  localparam int RD_AW     = 5;
  localparam int SL_AW     = 4;
  localparam int SLICE_W   = 8;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;

  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UNBLOCK = 3'd1;
  localparam logic [ACT_W-1:0] ACT_YIELD   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SLEEP   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_EXIT    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SETPRI  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED7 = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NORUN = 2'd2;

  typedef struct packed {
    logic [TASK_W-1:0] id;
    logic [PRI_W-1:0]  pri;
  } rd_ent_t;

  typedef struct packed {
    logic [TASK_W-1:0] id;
    logic [TIME_W-1:0] wake;
    logic [PRI_W-1:0]  pri;
  } sl_ent_t;

endpackage
`default_nettype wire

### rtl/priority_scheduler_with_sleep_queue.sv
`default_nettype none
// Channel  Dir  Signals
// in       in   in_valid/in_ready, action, task_id, task_priority, time_value
// out      out  out_valid/out_ready, running task/priority, idle, switched, woken, status
// cfg      in   cfg_valid/cfg_ready, cfg_slice_len
//
// One request at a time: accept, decode and result, plus the work below. Ordered insert
// (ready or sleep ring memory, one port each): read and write per entry compared, plus
// a write when it lands at the head. Dispatch: read and write, the read only if empty.
// Tick: wake-read and slice, plus read and check per sleeper woken or dropped, plus a
// check if one is left waiting. No clearing pass after reset; queue counts reset to
// zero. A finished result sits in the output register; the next result waits for it.
module priority_scheduler_with_sleep_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [sps_pkg::ACT_W-1:0]   in_action,
  input  wire logic [sps_pkg::TASK_W-1:0]  in_task_id,
  input  wire logic [sps_pkg::PRI_W-1:0]   in_task_priority,
  input  wire logic [sps_pkg::TIME_W-1:0]  in_time_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [sps_pkg::TASK_W-1:0]  out_running_task,
  output logic      [sps_pkg::PRI_W-1:0]   out_running_priority,
  output logic                             out_idle_running,
  output logic                             out_switched,
  output logic      [sps_pkg::CNT_W-1:0]   out_woken_count,
  output logic      [sps_pkg::STAT_W-1:0]  out_status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sps_pkg::SLICE_W-1:0] cfg_slice_len
);
  import sps_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_EXEC     = 12'b000000000010,
    S_WAKE_RD  = 12'b000000000100,
    S_WAKE_CHK = 12'b000000001000,
    S_SLICE    = 12'b000000010000,
    S_RINS_RD  = 12'b000000100000,
    S_RINS_WR  = 12'b000001000000,
    S_SINS_RD  = 12'b000010000000,
    S_SINS_WR  = 12'b000100000000,
    S_DISP_RD  = 12'b001000000000,
    S_DISP_WR  = 12'b010000000000,
    S_FINAL    = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {RET_WAKE, RET_UNBLK, RET_DISP} ret_t;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;

  logic [ACT_W-1:0]   act_r;
  logic [TASK_W-1:0]  tid_r;
  logic [PRI_W-1:0]   pri_r;
  logic [TIME_W-1:0]  tv_r;
  logic [TASK_W-1:0]  prev_task_r;
  logic               prev_idle_r;

  logic [TASK_W-1:0]  cur_task_r, cur_task_nxt;
  logic [PRI_W-1:0]   cur_pri_r, cur_pri_nxt;
  logic               cur_idle_r, cur_idle_nxt;
  logic [SLICE_W-1:0] slice_r, slice_nxt;
  logic [SLICE_W-1:0] ts_r;
  logic [RD_AW-1:0]   rd_head_r, rd_head_nxt;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [SL_AW-1:0]   sl_head_r, sl_head_nxt;
  logic [CNT_W-1:0]   sl_cnt_r, sl_cnt_nxt;
  logic [CNT_W-1:0]   ins_i_r, ins_i_nxt;
  logic [TASK_W-1:0]  ins_id_r, ins_id_nxt;
  logic [PRI_W-1:0]   ins_pri_r, ins_pri_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [CNT_W-1:0]   woken_r, woken_nxt;
  logic               preempt_r, preempt_nxt;

  logic               out_valid_r;
  logic [TASK_W-1:0]  out_task_r;
  logic [PRI_W-1:0]   out_pri_r;
  logic               out_idle_r;
  logic               out_sw_r;
  logic [CNT_W-1:0]   out_woken_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_load;

  logic               rq_we;
  logic [RD_AW-1:0]   rq_waddr, rq_raddr;
  rd_ent_t            rq_wdata, rq_rdata;
  logic               sq_we;
  logic [SL_AW-1:0]   sq_waddr, sq_raddr;
  sl_ent_t            sq_wdata, sq_rdata;

  logic               yield_go;
  logic [PRI_W-1:0]   yield_pri;
  logic               ins_done;
  logic [SLICE_W-1:0] slice_inc;

  sps_ram #(.WIDTH($bits(rd_ent_t)), .AW(RD_AW)) u_rq (
    .clk, .wr_en(rq_we), .wr_addr(rq_waddr), .wr_data(rq_wdata),
    .rd_addr(rq_raddr), .rd_data(rq_rdata)
  );

  sps_ram #(.WIDTH($bits(sl_ent_t)), .AW(SL_AW)) u_sq (
    .clk, .wr_en(sq_we), .wr_addr(sq_waddr), .wr_data(sq_wdata),
    .rd_addr(sq_raddr), .rd_data(sq_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slice_inc = slice_r + SLICE_W'(1);

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    cur_task_nxt = cur_task_r;
    cur_pri_nxt  = cur_pri_r;
    cur_idle_nxt = cur_idle_r;
    slice_nxt    = slice_r;
    rd_head_nxt  = rd_head_r;
    rd_cnt_nxt   = rd_cnt_r;
    sl_head_nxt  = sl_head_r;
    sl_cnt_nxt   = sl_cnt_r;
    ins_i_nxt    = ins_i_r;
    ins_id_nxt   = ins_id_r;
    ins_pri_nxt  = ins_pri_r;
    status_nxt   = status_r;
    woken_nxt    = woken_r;
    preempt_nxt  = preempt_r;
    out_load     = 1'b0;
    rq_we        = 1'b0;
    rq_waddr     = RD_AW'(rd_head_r + ins_i_r);
    rq_wdata     = '{id: ins_id_r, pri: ins_pri_r};
    rq_raddr     = rd_head_r;
    sq_we        = 1'b0;
    sq_waddr     = SL_AW'(sl_head_r + ins_i_r[SL_AW-1:0]);
    sq_wdata     = '{id: cur_task_r, wake: tv_r, pri: cur_pri_r};
    sq_raddr     = sl_head_r;
    yield_go     = 1'b0;
    yield_pri    = cur_pri_r;
    ins_done     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt  = ST_OK;
          woken_nxt   = '0;
          preempt_nxt = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FINAL;
        unique case (act_r)
          ACT_TICK: state_nxt = S_WAKE_RD;
          ACT_UNBLOCK: begin
            if (rd_cnt_r < CNT_W'(MAX_TASKS)) begin
              ins_id_nxt  = tid_r;
              ins_pri_nxt = pri_r;
              ins_i_nxt   = rd_cnt_r;
              ret_nxt     = RET_UNBLK;
              state_nxt   = S_RINS_RD;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          ACT_YIELD: yield_go = 1'b1;
          ACT_SLEEP: begin
            if (cur_idle_r) begin
              status_nxt = ST_NORUN;
            end else if (sl_cnt_r < CNT_W'(MAX_TASKS)) begin
              ins_i_nxt = sl_cnt_r;
              state_nxt = S_SINS_RD;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          ACT_EXIT: begin
            if (cur_idle_r) status_nxt = ST_NORUN;
            else state_nxt = S_DISP_RD;
          end
          ACT_SETPRI: begin
            if (cur_idle_r) begin
              status_nxt = ST_NORUN;
            end else begin
              cur_pri_nxt = pri_r;
              if (cur_pri_r > pri_r) begin
                yield_go  = 1'b1;
                yield_pri = pri_r;
              end
            end
          end
          default: state_nxt = S_FINAL;
        endcase
      end
      S_WAKE_RD: begin
        if (sl_cnt_r == '0) state_nxt = S_SLICE;
        else state_nxt = S_WAKE_CHK;
      end
      S_WAKE_CHK: begin
        if (tv_r < sq_rdata.wake) begin
          state_nxt = S_SLICE;
        end else begin
          sl_head_nxt = sl_head_r + SL_AW'(1);
          sl_cnt_nxt  = sl_cnt_r - CNT_W'(1);
          if (rd_cnt_r < CNT_W'(MAX_TASKS)) begin
            ins_id_nxt  = sq_rdata.id;
            ins_pri_nxt = sq_rdata.pri;
            ins_i_nxt   = rd_cnt_r;
            ret_nxt     = RET_WAKE;
            woken_nxt   = woken_r + CNT_W'(1);
            if (!cur_idle_r && sq_rdata.pri > cur_pri_r) preempt_nxt = 1'b1;
            state_nxt   = S_RINS_RD;
          end else begin
            status_nxt = ST_FULL;
            state_nxt  = S_WAKE_RD;
          end
        end
      end
      S_SLICE: begin
        slice_nxt = slice_inc;
        if (preempt_r || slice_inc >= ts_r) yield_go = 1'b1;
        else state_nxt = S_FINAL;
      end
      S_RINS_RD: begin
        if (ins_i_r == '0) begin
          rq_we      = 1'b1;
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          ins_done   = 1'b1;
        end else begin
          rq_raddr  = RD_AW'(rd_head_r + ins_i_r - CNT_W'(1));
          state_nxt = S_RINS_WR;
        end
      end
      S_RINS_WR: begin
        rq_we = 1'b1;
        if (rq_rdata.pri >= ins_pri_r) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          ins_done   = 1'b1;
        end else begin
          rq_wdata  = rq_rdata;
          ins_i_nxt = ins_i_r - CNT_W'(1);
          state_nxt = S_RINS_RD;
        end
      end
      S_SINS_RD: begin
        if (ins_i_r == '0) begin
          sq_we      = 1'b1;
          sl_cnt_nxt = sl_cnt_r + CNT_W'(1);
          state_nxt  = S_DISP_RD;
        end else begin
          sq_raddr  = SL_AW'(sl_head_r + ins_i_r[SL_AW-1:0] - SL_AW'(1));
          state_nxt = S_SINS_WR;
        end
      end
      S_SINS_WR: begin
        sq_we = 1'b1;
        if (!(tv_r < sq_rdata.wake)) begin
          sl_cnt_nxt = sl_cnt_r + CNT_W'(1);
          state_nxt  = S_DISP_RD;
        end else begin
          sq_wdata  = sq_rdata;
          ins_i_nxt = ins_i_r - CNT_W'(1);
          state_nxt = S_SINS_RD;
        end
      end
      S_DISP_RD: begin
        slice_nxt = '0;
        if (rd_cnt_r == '0) begin
          cur_task_nxt = '0;
          cur_pri_nxt  = '0;
          cur_idle_nxt = 1'b1;
          state_nxt    = S_FINAL;
        end else begin
          state_nxt = S_DISP_WR;
        end
      end
      S_DISP_WR: begin
        cur_task_nxt = rq_rdata.id;
        cur_pri_nxt  = rq_rdata.pri;
        cur_idle_nxt = 1'b0;
        rd_head_nxt  = rd_head_r + RD_AW'(1);
        rd_cnt_nxt   = rd_cnt_r - CNT_W'(1);
        state_nxt    = S_FINAL;
      end
      S_FINAL: begin
        if (cur_idle_r && rd_cnt_r != '0) begin
          state_nxt = S_DISP_RD;
        end else if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (ins_done) begin
      case (ret_r)
        RET_WAKE: state_nxt = S_WAKE_RD;
        RET_UNBLK: begin
          if (!cur_idle_r && pri_r > cur_pri_r) yield_go = 1'b1;
          else state_nxt = S_FINAL;
        end
        default: state_nxt = S_DISP_RD;
      endcase
    end

    if (yield_go) begin
      if (!cur_idle_r) begin
        ins_id_nxt  = cur_task_r;
        ins_pri_nxt = yield_pri;
        ins_i_nxt   = rd_cnt_nxt;
        ret_nxt     = RET_DISP;
        state_nxt   = S_RINS_RD;
      end else begin
        state_nxt = S_DISP_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_DISP;
      cur_task_r  <= '0;
      cur_pri_r   <= '0;
      cur_idle_r  <= 1'b1;
      slice_r     <= '0;
      ts_r        <= SLICE_RESET;
      rd_head_r   <= '0;
      rd_cnt_r    <= '0;
      sl_head_r   <= '0;
      sl_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      cur_task_r <= cur_task_nxt;
      cur_pri_r  <= cur_pri_nxt;
      cur_idle_r <= cur_idle_nxt;
      slice_r    <= slice_nxt;
      rd_head_r  <= rd_head_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      sl_head_r  <= sl_head_nxt;
      sl_cnt_r   <= sl_cnt_nxt;
      if (cfg_valid) ts_r <= cfg_slice_len;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ins_i_r   <= ins_i_nxt;
    ins_id_r  <= ins_id_nxt;
    ins_pri_r <= ins_pri_nxt;
    status_r  <= status_nxt;
    woken_r   <= woken_nxt;
    preempt_r <= preempt_nxt;
    if (in_valid && in_ready) begin
      act_r       <= in_action;
      tid_r       <= in_task_id;
      pri_r       <= in_task_priority;
      tv_r        <= in_time_value;
      prev_task_r <= cur_task_r;
      prev_idle_r <= cur_idle_r;
    end
    if (out_load) begin
      out_task_r   <= cur_idle_r ? '0 : cur_task_r;
      out_pri_r    <= cur_idle_r ? '0 : cur_pri_r;
      out_idle_r   <= cur_idle_r;
      out_sw_r     <= (prev_idle_r != cur_idle_r) ||
                      (!cur_idle_r && prev_task_r != cur_task_r);
      out_woken_r  <= woken_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_running_task     = out_task_r;
  assign out_running_priority = out_pri_r;
  assign out_idle_running     = out_idle_r;
  assign out_switched         = out_sw_r;
  assign out_woken_count      = out_woken_r;
  assign out_status           = out_status_r;

  a_rd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= CNT_W'(MAX_TASKS + 1))
    else $error("ready count overflow");

  a_sl_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    sl_cnt_r <= CNT_W'(MAX_TASKS))
    else $error("sleep count overflow");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cur_idle_r) |-> rd_cnt_r == '0)
    else $error("idle with ready tasks");

  a_rd_cnt_rest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> rd_cnt_r <= CNT_W'(MAX_TASKS))
    else $error("spare ready slot in use between requests");

endmodule
`default_nettype wire

### rtl/sps_ram.sv
`default_nettype none
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sps_pkg::*;

  typedef struct {
    logic [TASK_W-1:0] task_id;
    logic [PRI_W-1:0]  pri;
    logic              idle;
    logic              switched;
    logic [CNT_W-1:0]  woken;
    logic [STAT_W-1:0] status;
  } sched_res_t;

  class sched_scoreboard;
    logic [TASK_W-1:0] rq_id[$];
    logic [PRI_W-1:0]  rq_pri[$];
    logic [TASK_W-1:0] sq_id[$];
    logic [TIME_W-1:0] sq_wake[$];
    logic [PRI_W-1:0]  sq_pri[$];
    logic [TASK_W-1:0] cur_id;
    logic [PRI_W-1:0]  cur_pri;
    logic              cur_idle;
    logic [SLICE_W-1:0] slice_cnt;
    logic [SLICE_W-1:0] slice_len;
    sched_res_t        pending[$];
    int                errors;

    function new();
      cur_id = 0; cur_pri = 0; cur_idle = 1; slice_cnt = 0;
      slice_len = SLICE_RESET; errors = 0;
    endfunction

    function void ready_insert(logic [TASK_W-1:0] id, logic [PRI_W-1:0] p);
      int pos;
      pos = 0;
      while (pos < rq_id.size() && rq_pri[pos] >= p) pos++;
      rq_id.insert(pos, id);
      rq_pri.insert(pos, p);
    endfunction

    function void dispatch();
      if (rq_id.size() > 0) begin
        cur_id = rq_id.pop_front();
        cur_pri = rq_pri.pop_front();
        cur_idle = 0;
      end else begin
        cur_id = 0; cur_pri = 0; cur_idle = 1;
      end
      slice_cnt = 0;
    endfunction

    function void requeue_running();
      if (!cur_idle) ready_insert(cur_id, cur_pri);
      dispatch();
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [TASK_W-1:0] id,
                               logic [PRI_W-1:0] p, logic [TIME_W-1:0] tv);
      logic [TASK_W-1:0] prev_id;
      logic prev_idle, preempt;
      logic [PRI_W-1:0] sp, old;
      logic [TASK_W-1:0] sid;
      int pos;
      sched_res_t r;
      prev_id = cur_id; prev_idle = cur_idle; preempt = 0;
      r.woken = 0; r.status = ST_OK;
      case (act)
        ACT_TICK: begin
          while (sq_id.size() > 0 && !(tv < sq_wake[0])) begin
            sid = sq_id.pop_front();
            sp = sq_pri.pop_front();
            void'(sq_wake.pop_front());
            if (rq_id.size() < MAX_TASKS) begin
              ready_insert(sid, sp);
              r.woken++;
              if (!cur_idle && sp > cur_pri) preempt = 1;
            end else r.status = ST_FULL;
          end
          slice_cnt++;
          if (slice_cnt >= slice_len) preempt = 1;
          if (preempt) requeue_running();
        end
        ACT_UNBLOCK: begin
          if (rq_id.size() < MAX_TASKS) begin
            ready_insert(id, p);
            if (!cur_idle && p > cur_pri) requeue_running();
          end else r.status = ST_FULL;
        end
        ACT_YIELD: requeue_running();
        ACT_SLEEP: begin
          if (cur_idle) r.status = ST_NORUN;
          else if (sq_id.size() < MAX_TASKS) begin
            pos = 0;
            while (pos < sq_id.size() && !(tv < sq_wake[pos])) pos++;
            sq_id.insert(pos, cur_id);
            sq_wake.insert(pos, tv);
            sq_pri.insert(pos, cur_pri);
            dispatch();
          end else r.status = ST_FULL;
        end
        ACT_EXIT: begin
          if (cur_idle) r.status = ST_NORUN;
          else dispatch();
        end
        ACT_SETPRI: begin
          if (cur_idle) r.status = ST_NORUN;
          else begin
            old = cur_pri;
            cur_pri = p;
            if (old > p) requeue_running();
          end
        end
        default: ;
      endcase
      if (cur_idle && rq_id.size() > 0) dispatch();
      r.task_id = cur_idle ? '0 : cur_id;
      r.pri = cur_idle ? '0 : cur_pri;
      r.idle = cur_idle;
      r.switched = (prev_idle != cur_idle) || (!cur_idle && prev_id != cur_id);
      pending.push_back(r);
    endfunction

    function void check_result(sched_res_t a);
      sched_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result task=%0d", $time, a.task_id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.task_id !== e.task_id) begin
        $display("%0t: running_task exp %0d act %0d", $time, e.task_id, a.task_id); errors++;
      end
      if (a.pri !== e.pri) begin
        $display("%0t: running_priority exp %0d act %0d", $time, e.pri, a.pri); errors++;
      end
      if (a.idle !== e.idle) begin
        $display("%0t: idle_running exp %0d act %0d", $time, e.idle, a.idle); errors++;
      end
      if (a.switched !== e.switched) begin
        $display("%0t: switched exp %0d act %0d", $time, e.switched, a.switched); errors++;
      end
      if (a.woken !== e.woken) begin
        $display("%0t: woken_count exp %0d act %0d", $time, e.woken, a.woken); errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d act %0d", $time, e.status, a.status); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [ACT_W-1:0] in_action;
  logic [TASK_W-1:0] in_task_id;
  logic [PRI_W-1:0] in_task_priority;
  logic [TIME_W-1:0] in_time_value;
  logic out_valid, out_ready;
  logic [TASK_W-1:0] out_running_task;
  logic [PRI_W-1:0] out_running_priority;
  logic out_idle_running, out_switched;
  logic [CNT_W-1:0] out_woken_count;
  logic [STAT_W-1:0] out_status;
  logic cfg_valid, cfg_ready;
  logic [SLICE_W-1:0] cfg_slice_len;

  sched_scoreboard sb;
  logic no_idling;
  logic [TIME_W-1:0] now_time;

  priority_scheduler_with_sleep_queue dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall bursts, checked on accept
  initial begin
    int gap;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result('{out_running_task, out_running_priority, out_idle_running,
                          out_switched, out_woken_count, out_status});
      end
      if (!no_idling && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (gap - 1) @(posedge clk);
      end else out_ready <= 1;
    end
  end

  task automatic send_req(logic [ACT_W-1:0] act, logic [TASK_W-1:0] id,
                          logic [PRI_W-1:0] p, logic [TIME_W-1:0] tv);
    if (!no_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_task_id <= id;
    in_task_priority <= p;
    in_time_value <= tv;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, id, p, tv);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_slice(logic [SLICE_W-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_slice_len <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.slice_len = v;
    cfg_valid <= 0;
  endtask

  task automatic random_req();
    int k;
    logic [TIME_W-1:0] tv;
    logic [TASK_W-1:0] id;
    logic [PRI_W-1:0] p;
    k = $urandom_range(0, 99);
    id = TASK_W'($urandom);
    p = PRI_W'($urandom);
    tv = $urandom;
    if (k < 25) begin
      now_time = now_time + $urandom_range(0, 6);
      send_req(ACT_TICK, id, p, now_time);
    end else if (k < 50) send_req(ACT_UNBLOCK, id, p, tv);
    else if (k < 60) send_req(ACT_YIELD, id, p, tv);
    else if (k < 75) begin
      if ($urandom_range(0, 9) != 0) tv = now_time + $urandom_range(0, 20);
      send_req(ACT_SLEEP, id, p, tv);
    end else if (k < 83) send_req(ACT_EXIT, id, p, tv);
    else if (k < 96) send_req(ACT_SETPRI, id, p, tv);
    else send_req(($urandom_range(0, 1) == 0) ? ACT_UNUSED6 : ACT_UNUSED7, id, p, tv);
  endtask

  initial begin
    logic [SLICE_W-1:0] slices[4];
    int i, ph;
    sb = new();
    no_idling = 0;
    now_time = 0;
    rst_n = 0;
    in_valid = 0; in_action = 0; in_task_id = 0; in_task_priority = 0; in_time_value = 0;
    cfg_valid = 0; cfg_slice_len = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: commands while idle, extremes, full queues, wakeups
    send_req(ACT_SLEEP, '0, '0, '0);
    send_req(ACT_EXIT, '0, '0, '0);
    send_req(ACT_SETPRI, '0, 6'd63, '0);
    send_req(ACT_YIELD, '0, '0, '0);
    send_req(ACT_UNBLOCK, 4'd15, 6'd63, 32'hFFFF_FFFF);
    send_req(ACT_UNBLOCK, '0, '0, '0);
    send_req(ACT_SETPRI, '0, '0, '0);
    send_req(ACT_SLEEP, '0, '0, 32'hFFFF_FFFF);
    send_req(ACT_TICK, '0, '0, 32'hFFFF_FFFF);
    send_req(ACT_UNUSED6, 4'd5, 6'd5, 32'd5);
    send_req(ACT_UNUSED7, 4'd10, 6'd42, 32'h5555_AAAA);
    for (i = 0; i < 17; i++) send_req(ACT_UNBLOCK, TASK_W'(i), PRI_W'(i * 3), '0);
    for (i = 0; i < 17; i++) send_req(ACT_SLEEP, '0, '0, 32'd100);
    send_req(ACT_TICK, '0, '0, 32'd200);

    slices[0] = 8'd1; slices[1] = 8'd255; slices[2] = 8'd0; slices[3] = 8'd3;
    for (ph = 0; ph < 5; ph++) begin
      if (ph < 4) write_slice(slices[ph]);
      if (ph == 4) no_idling = 1;
      for (i = 0; i < 330; i++) random_req();
      if (ph == 1) drain();
    end
    drain();
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

### files.f
rtl/sps_pkg.sv
rtl/sps_ram.sv
rtl/priority_scheduler_with_sleep_queue.sv
dv/testbench.sv
